FILE: hdl/scp_pkg.sv
package scp_pkg;

  localparam int MaxSamples = 4096;
  localparam int SampleW    = $clog2(MaxSamples + 1);
  localparam int CapW       = 13;
  localparam int ByteW      = 8;
  localparam int PeriodW    = 22;
  localparam int IdxW       = 6;
  localparam int CntW       = 19;
  localparam int DivInW     = 27;
  localparam int ProdW      = 54;
  localparam int RecipShift = 31;

  // Rounded-up reciprocal of 25 scaled by 2**31; exact for dividends below 2**30.
  localparam logic [DivInW-1:0] Recip = 27'd85899346;

  localparam logic [ByteW-1:0] CMD_RESET    = 8'h00;
  localparam logic [ByteW-1:0] CMD_RUN      = 8'h01;
  localparam logic [ByteW-1:0] CMD_ID       = 8'h02;
  localparam logic [ByteW-1:0] CMD_META     = 8'h04;
  localparam logic [ByteW-1:0] CMD_XON      = 8'h11;
  localparam logic [ByteW-1:0] CMD_XOFF     = 8'h13;
  localparam logic [ByteW-1:0] CMD_DIVIDER  = 8'h80;
  localparam logic [ByteW-1:0] CMD_SAMPLES  = 8'h81;
  localparam logic [ByteW-1:0] CMD_TRIG_MSK = 8'hc0;
  localparam logic [ByteW-1:0] CMD_TRIG_VAL = 8'hc1;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_CAPTURE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ID   = 2'd1,
    OP_META = 2'd2,
    OP_RUN  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SampleW-1:0] samples_before;
    logic [SampleW-1:0] samples_after;
    logic [ByteW-1:0]   mask;
    logic [ByteW-1:0]   level;
    logic [PeriodW-1:0] period;
  } desc_t;

  typedef struct packed {
    kind_t              kind;
    logic [ByteW-1:0]   reply;
    logic [CapW-1:0]    samples;
    logic [ByteW-1:0]   mask;
    logic [ByteW-1:0]   level;
    logic [PeriodW-1:0] period;
    logic               last;
  } item_t;

  function automatic logic [IdxW-1:0] reply_len(op_t op);
    logic [IdxW-1:0] len;
    case (op)
      OP_ID:   len = 6'd4;
      OP_META: len = 6'd37;
      OP_RUN:  len = 6'd1;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] id_rom(logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      6'd0:    b = 8'h31;
      6'd1:    b = 8'h41;
      6'd2:    b = 8'h4C;
      6'd3:    b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] meta_rom(logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      6'd0:    b = 8'h01;
      6'd1:    b = 8'h42;
      6'd2:    b = 8'h75;
      6'd3:    b = 8'h73;
      6'd4:    b = 8'h20;
      6'd5:    b = 8'h50;
      6'd6:    b = 8'h69;
      6'd7:    b = 8'h72;
      6'd8:    b = 8'h61;
      6'd9:    b = 8'h74;
      6'd10:   b = 8'h65;
      6'd11:   b = 8'h20;
      6'd12:   b = 8'h4E;
      6'd13:   b = 8'h47;
      6'd14:   b = 8'h31;
      6'd15:   b = 8'h00;
      6'd16:   b = 8'h02;
      6'd17:   b = 8'h46;
      6'd18:   b = 8'h77;
      6'd19:   b = 8'h76;
      6'd20:   b = 8'h31;
      6'd21:   b = 8'h00;
      6'd22:   b = 8'h21;
      6'd23:   b = 8'h00;
      6'd24:   b = 8'h04;
      6'd25:   b = 8'h00;
      6'd26:   b = 8'h00;
      6'd27:   b = 8'h23;
      6'd28:   b = 8'h02;
      6'd29:   b = 8'h25;
      6'd30:   b = 8'h51;
      6'd31:   b = 8'h00;
      6'd32:   b = 8'h40;
      6'd33:   b = 8'h08;
      6'd34:   b = 8'h41;
      6'd35:   b = 8'h02;
      6'd36:   b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/scp_front.sv
module scp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  q_full,
  output logic                  q_push,
  output scp_pkg::desc_t        q_desc
);

  logic                              collecting_r, collecting_nxt;
  logic [scp_pkg::ByteW-1:0]         opcode_r, opcode_nxt;
  logic [1:0]                        cnt_r, cnt_nxt;
  logic [scp_pkg::ByteW-1:0]         p0_r, p0_nxt;
  logic [scp_pkg::ByteW-1:0]         p1_r, p1_nxt;
  logic [scp_pkg::ByteW-1:0]         p2_r, p2_nxt;
  logic [scp_pkg::SampleW-1:0]       samples_r, samples_nxt;
  logic [scp_pkg::ByteW-1:0]         mask_r, mask_nxt;
  logic [scp_pkg::ByteW-1:0]         level_r, level_nxt;
  logic [scp_pkg::PeriodW-1:0]       period_r, period_nxt;
  logic                              div_busy_r, div_busy_nxt;
  logic [scp_pkg::ProdW-1:0]         div_prod_r, div_prod_nxt;
  logic                              accept;
  scp_pkg::op_t                      op;
  logic [16:0]                       cnt_sum;
  logic [scp_pkg::CntW-1:0]          cnt_words;
  logic [24:0]                       div_sum;
  logic [scp_pkg::DivInW-1:0]        div_in;

  assign in_ready = !div_busy_r && !q_full;
  assign accept   = in_valid && in_ready;

  assign cnt_sum      = {1'b0, p1_r, p0_r} + 17'd1;
  assign cnt_words    = {cnt_sum, 2'b00};
  assign div_sum      = {1'b0, p2_r, p1_r, p0_r} + 25'd1;
  assign div_in       = {div_sum, 2'b00};
  assign div_prod_nxt = scp_pkg::ProdW'(div_in) * scp_pkg::ProdW'(scp_pkg::Recip);

  always_comb begin
    collecting_nxt = collecting_r;
    opcode_nxt     = opcode_r;
    cnt_nxt        = cnt_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    samples_nxt    = samples_r;
    mask_nxt       = mask_r;
    level_nxt      = level_r;
    period_nxt     = period_r;
    div_busy_nxt   = 1'b0;
    q_push         = 1'b0;
    op             = scp_pkg::OP_NONE;
    if (div_busy_r) begin
      period_nxt = div_prod_r[scp_pkg::RecipShift +: scp_pkg::PeriodW];
      q_push     = 1'b1;
    end else if (accept) begin
      q_push = 1'b1;
      if (collecting_r) begin
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd0: p0_nxt = in_byte;
          2'd1: p1_nxt = in_byte;
          2'd2: p2_nxt = in_byte;
          default: begin
            collecting_nxt = 1'b0;
            cnt_nxt        = 2'd0;
            case (opcode_r)
              scp_pkg::CMD_TRIG_MSK: mask_nxt = p0_r;
              scp_pkg::CMD_TRIG_VAL: level_nxt = p0_r;
              scp_pkg::CMD_SAMPLES: begin
                if (cnt_words > scp_pkg::CntW'(scp_pkg::MaxSamples)) begin
                  samples_nxt = scp_pkg::SampleW'(scp_pkg::MaxSamples);
                end else begin
                  samples_nxt = scp_pkg::SampleW'(cnt_words);
                end
              end
              scp_pkg::CMD_DIVIDER: begin
                div_busy_nxt = 1'b1;
                q_push       = 1'b0;
              end
              default: ;
            endcase
          end
        endcase
      end else begin
        case (in_byte)
          scp_pkg::CMD_RESET: samples_nxt = scp_pkg::SampleW'(scp_pkg::MaxSamples);
          scp_pkg::CMD_ID:    op = scp_pkg::OP_ID;
          scp_pkg::CMD_META:  op = scp_pkg::OP_META;
          scp_pkg::CMD_RUN: begin
            op          = scp_pkg::OP_RUN;
            samples_nxt = scp_pkg::SampleW'(scp_pkg::MaxSamples);
          end
          scp_pkg::CMD_XON, scp_pkg::CMD_XOFF: ;
          default: begin
            collecting_nxt = 1'b1;
            opcode_nxt     = in_byte;
            cnt_nxt        = 2'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    q_desc.op             = op;
    q_desc.samples_before = samples_r;
    q_desc.samples_after  = samples_nxt;
    q_desc.mask           = mask_nxt;
    q_desc.level          = level_nxt;
    q_desc.period         = period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      opcode_r     <= '0;
      cnt_r        <= '0;
      samples_r    <= scp_pkg::SampleW'(scp_pkg::MaxSamples);
      mask_r       <= '0;
      level_r      <= '0;
      period_r     <= '0;
      div_busy_r   <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
      opcode_r     <= opcode_nxt;
      cnt_r        <= cnt_nxt;
      samples_r    <= samples_nxt;
      mask_r       <= mask_nxt;
      level_r      <= level_nxt;
      period_r     <= period_nxt;
      div_busy_r   <= div_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    div_prod_r <= div_prod_nxt;
  end

endmodule

FILE: hdl/scp_queue.sv
module scp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scp_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output scp_pkg::desc_t head
);

  scp_pkg::desc_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: hdl/scp_back.sv
module scp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  scp_pkg::desc_t head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output scp_pkg::item_t out_item
);

  logic                       out_valid_r;
  scp_pkg::item_t             item_r, item_nxt;
  logic [scp_pkg::IdxW-1:0]   idx_r, idx_nxt;
  logic                       load;
  logic                       is_rep;
  logic [scp_pkg::ByteW-1:0]  rom_byte;

  assign load      = !out_valid_r || out_ready;
  assign is_rep    = idx_r < scp_pkg::reply_len(head.op);
  assign q_pop     = load && !q_empty && !is_rep;
  assign out_valid = out_valid_r;
  assign out_item  = item_r;

  always_comb begin
    case (head.op)
      scp_pkg::OP_ID:   rom_byte = scp_pkg::id_rom(idx_r);
      scp_pkg::OP_META: rom_byte = scp_pkg::meta_rom(idx_r);
      default:          rom_byte = '0;
    endcase
  end

  always_comb begin
    item_nxt.mask   = head.mask;
    item_nxt.level  = head.level;
    item_nxt.period = head.period;
    if (is_rep) begin
      item_nxt.kind    = (head.op == scp_pkg::OP_RUN) ? scp_pkg::KIND_CAPTURE
                                                      : scp_pkg::KIND_REPLY;
      item_nxt.reply   = rom_byte;
      item_nxt.samples = scp_pkg::CapW'(head.samples_before);
      item_nxt.last    = 1'b0;
      idx_nxt          = idx_r + 6'd1;
    end else begin
      item_nxt.kind    = scp_pkg::KIND_STATUS;
      item_nxt.reply   = '0;
      item_nxt.samples = scp_pkg::CapW'(head.samples_after);
      item_nxt.last    = 1'b1;
      idx_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hdl/sump_command_parser.sv
// Host command decoder for a logic analyzer link. It takes one command byte per
// cycle while its two-entry command queue has room; the last parameter byte of a
// divider command stalls the input while the period is scaled through a registered
// reciprocal multiply. Each byte yields 1, 2, 5 or 38 output words, one per cycle
// from the output register while the receiver is ready, so output throughput is set
// by the length of the reply bursts; the output register lets the front keep taking
// bytes while a word waits.
module sump_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // host_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // reply_byte[7:0], capture_samples[20:8],
                                  // trigger_mask_out[28:21], trigger_level_out[36:29],
                                  // sample_period_out[58:37], zero[63:59]
  output logic [1:0]  out_tuser,  // result_kind[1:0]
  output logic        out_tlast   // last_of_run
);

  logic           q_push, q_full, q_pop, q_empty;
  scp_pkg::desc_t push_desc, head;
  scp_pkg::item_t item;

  scp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  scp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tdata = {5'b0, item.period, item.level, item.mask, item.samples, item.reply};
  assign out_tuser = item.kind;
  assign out_tlast = item.last;

`ifndef SYNTHESIS
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == scp_pkg::KIND_STATUS)
    else $error("final word of a command is not a status word");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == scp_pkg::KIND_STATUS |-> out_tlast)
    else $error("status word not marked as last");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_capture_then_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == scp_pkg::KIND_CAPTURE
    |=> out_tvalid && out_tuser == scp_pkg::KIND_STATUS)
    else $error("capture word not followed by its status word");
`endif

endmodule
